FILE: hw/rtl/bdp_pkg.sv
`default_nettype none

package bdp_pkg;

    localparam int unsigned BDP_DATA_W    = 64;
    localparam int unsigned BDP_WIDTH_W   = 7;
    localparam int unsigned BDP_LOWER_W   = 6;
    localparam int unsigned BDP_MAX_WIDTH = 64;

    typedef logic [BDP_DATA_W-1:0]  t_mask;
    typedef logic [BDP_WIDTH_W-1:0] t_width;

    typedef enum logic [2:0] {
        OP_EQ     = 3'd0,
        OP_NOT    = 3'd1,
        OP_SHL    = 3'd2,
        OP_SHR    = 3'd3,
        OP_AND    = 3'd4,
        OP_SLICE  = 3'd5,
        OP_CONCAT = 3'd6,
        OP_RSVD   = 3'd7
    } t_opcode;

    typedef struct packed {
        t_opcode                opcode;
        t_mask                  x_lo;
        t_mask                  x_hi;
        t_mask                  y_lo;
        t_mask                  y_hi;
        t_mask                  z_lo;
        t_mask                  z_hi;
        t_width                 width_x;
        t_width                 width_y;
        t_width                 shift_or_upper;
        logic [BDP_LOWER_W-1:0] lower_bit;
    } t_bdp_req;

    typedef struct packed {
        t_mask new_x_lo;
        t_mask new_x_hi;
        t_mask new_y_lo;
        t_mask new_y_hi;
        t_mask new_z_lo;
        t_mask new_z_hi;
        logic  eq_lo;
        logic  eq_hi;
        logic  bad_request;
    } t_bdp_rsp;

    // Ones in the low w bits; all ones from the full data width upward.
    function automatic t_mask wmask(input t_width w);
        t_mask m;
        if (w >= t_width'(BDP_DATA_W)) begin
            m = '1;
        end else begin
            m = (t_mask'(1) << w) - t_mask'(1);
        end
        return m;
    endfunction

    function automatic logic width_ok(input t_width w);
        return (w >= t_width'(1)) && (w <= t_width'(BDP_MAX_WIDTH));
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bdp_if.sv
`default_nettype none

interface bdp_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bitvector_domain_propagator_top.sv
// Known-bits domain propagator for bit-vector constraints.
// i_in (sink, t_bdp_req): one word names a rule (eq, not, shl, shr, and,
//   slice, concat) and carries the lo/hi masks of x, y and z plus widths,
//   shift amount or slice bounds.
// o_out (source, t_bdp_rsp): one word per input word with the tightened
//   domains, the equality result domain and a bad_request flag; on
//   bad_request every other field is zero, and masks are zero above the
//   operand width.
// Path: an accepted word goes into the input register, then through the
//   rule logic into the result register, which drives o_out.
// Throughput: one word per cycle; both registers advance together, so a
//   new word is taken in every cycle the result side is not stalled.
// Stall: while o_out.ready is low the result holds, the input register
//   still fills if empty, and i_in.ready drops once both are full.
// Reset (i_rst_n low, synchronous) empties both registers; the block keeps
//   no other state.
`default_nettype none

module bitvector_domain_propagator_top (
    input  wire    i_clk,
    input  wire    i_rst_n,
    bdp_if.sink    i_in,
    bdp_if.source  o_out
);
    import bdp_pkg::*;

    logic     r_v1;
    logic     r_v2;
    t_bdp_req r_req;
    t_bdp_rsp r_rsp;
    t_bdp_rsp n_rsp;
    logic     s1_adv;

    assign s1_adv      = !r_v2 || o_out.ready;
    assign i_in.ready  = !r_v1 || s1_adv;
    assign o_out.valid = r_v2;
    assign o_out.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_v1 <= i_in.valid;
            end
            if (s1_adv) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req <= i_in.data;
        end
        if (s1_adv && r_v1) begin
            r_rsp <= n_rsp;
        end
    end

    always_comb begin
        t_mask  mx, my, mz, m1, m2, field;
        t_mask  xl, xh, yl, yh, zl, zh, zlm, zhm, lo, hi;
        t_width wx, wy, su, lb, n, zw;
        logic [BDP_WIDTH_W:0] wsum;
        logic   bad;

        wx    = r_req.width_x;
        wy    = r_req.width_y;
        su    = r_req.shift_or_upper;
        lb    = t_width'(r_req.lower_bit);
        mx    = wmask(wx);
        xl    = r_req.x_lo & mx;
        xh    = r_req.x_hi & mx;
        yl    = r_req.y_lo;
        yh    = r_req.y_hi;
        zl    = r_req.z_lo;
        zh    = r_req.z_hi;
        zlm   = zl & mx;
        zhm   = zh & mx;
        n     = (su > wx) ? wx : su;
        zw    = su - lb + t_width'(1);
        mz    = wmask(zw);
        my    = wmask(wy);
        wsum  = {1'b0, wx} + {1'b0, wy};
        m1    = '0;
        m2    = '0;
        field = '0;
        lo    = '0;
        hi    = '0;
        bad   = !width_ok(wx);
        n_rsp = '0;

        unique case (r_req.opcode)
            OP_EQ: begin
                lo = (xl | yl) & mx;
                hi = xh & yh & mx;
                n_rsp.new_x_lo = lo;
                n_rsp.new_x_hi = hi;
                if ((lo & ~hi) != '0) begin
                    n_rsp.eq_lo = 1'b0;
                    n_rsp.eq_hi = 1'b0;
                end else if (lo == hi) begin
                    n_rsp.eq_lo = 1'b1;
                    n_rsp.eq_hi = 1'b1;
                end else begin
                    n_rsp.eq_lo = 1'b0;
                    n_rsp.eq_hi = 1'b1;
                end
            end
            OP_NOT: begin
                n_rsp.new_x_lo = (xl | ~zhm) & mx;
                n_rsp.new_x_hi = xh & ~zlm & mx;
                n_rsp.new_z_lo = (zlm | ~xh) & mx;
                n_rsp.new_z_hi = zhm & ~xl & mx;
            end
            OP_SHR: begin
                m1 = wmask(n);
                m2 = wmask(wx - n);
                n_rsp.new_x_lo = (xl | (zlm << n)) & mx;
                n_rsp.new_x_hi = ((zhm << n) | m1) & xh & mx;
                n_rsp.new_z_lo = ((xl >> n) | zlm) & m2;
                n_rsp.new_z_hi = (xh >> n) & zhm;
            end
            OP_SHL: begin
                m1 = mx & ~wmask(wx - n);
                m2 = (wmask(wx - n) << n) & mx;
                n_rsp.new_x_lo = (xl | (zlm >> n)) & mx;
                n_rsp.new_x_hi = ((zhm >> n) | m1) & xh & mx;
                n_rsp.new_z_lo = ((xl << n) | zlm) & m2;
                n_rsp.new_z_hi = (xh << n) & zhm & mx;
            end
            OP_AND: begin
                n_rsp.new_x_lo = (xl | zlm) & mx;
                n_rsp.new_x_hi = xh & ~(~zhm & yl & mx) & mx;
                n_rsp.new_y_lo = ((yl & mx) | zlm) & mx;
                n_rsp.new_y_hi = yh & mx & ~(~zhm & xl) & mx;
                n_rsp.new_z_lo = (zlm | (xl & yl & mx)) & mx;
                n_rsp.new_z_hi = zhm & xh & yh & mx;
            end
            OP_SLICE: begin
                if (su < lb || su >= wx) begin
                    bad = 1'b1;
                end
                lo    = ((xl >> lb) | zl) & mz;
                hi    = (xh >> lb) & zh & mz;
                field = mz << lb;
                n_rsp.new_z_lo = lo;
                n_rsp.new_z_hi = hi;
                n_rsp.new_x_lo = ((xl & ~field) | (lo << lb)) & mx;
                n_rsp.new_x_hi = ((xh & ~field) | (hi << lb)) & mx;
            end
            OP_CONCAT: begin
                if (!width_ok(wy) || wsum > (BDP_WIDTH_W+1)'(BDP_MAX_WIDTH)) begin
                    bad = 1'b1;
                end
                lo = ((zl >> wy) | xl) & mx;
                hi = (zh >> wy) & xh & mx;
                n_rsp.new_x_lo = lo;
                n_rsp.new_x_hi = hi;
                n_rsp.new_y_lo = (zl | yl) & my;
                n_rsp.new_y_hi = zh & yh & my;
                n_rsp.new_z_lo = (lo << wy) | ((zl | yl) & my);
                n_rsp.new_z_hi = (hi << wy) | (zh & yh & my);
            end
            default: begin
                bad = 1'b1;
            end
        endcase

        if (bad) begin
            n_rsp             = '0;
            n_rsp.bad_request = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bdp_checker.sv
`default_nettype none

module bdp_checker (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_valid,
    input wire                    i_ready,
    input wire bdp_pkg::t_bdp_rsp i_data
);
    import bdp_pkg::*;

    // A flagged word carries nothing else.
    a_bad_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_data.bad_request) |->
            (i_data.new_x_lo == '0 && i_data.new_x_hi == '0 &&
             i_data.new_y_lo == '0 && i_data.new_y_hi == '0 &&
             i_data.new_z_lo == '0 && i_data.new_z_hi == '0 &&
             !i_data.eq_lo && !i_data.eq_hi))
        else $error("bad_request word with nonzero fields");

    // Equality known true only for a fixed merged domain.
    a_eq_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_data.eq_lo) |->
            (i_data.eq_hi && i_data.new_x_lo == i_data.new_x_hi))
        else $error("eq true on a domain that is not fixed");

    // Equality may be true only for a consistent merged domain.
    a_eq_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_data.eq_hi) |->
            ((i_data.new_x_lo & ~i_data.new_x_hi) == '0))
        else $error("eq possible on an invalid domain");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_data)))
        else $error("stalled result word changed");

endmodule

bind bitvector_domain_propagator_top bdp_checker u_bdp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_data  (o_out.data)
);

`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none

module testbench;
    import bdp_pkg::*;

    // Holds the tightened domains still owed by the block and checks each result word.
    class domain_scoreboard;
        t_bdp_rsp    awaited[$];
        int unsigned domain_errors;
        int unsigned words_checked;

        function t_mask low_ones(int unsigned w);
            if (w == 0) begin
                return '0;
            end
            if (w >= BDP_DATA_W) begin
                return '1;
            end
            return (t_mask'(1) << w) - t_mask'(1);
        endfunction

        function t_bdp_rsp propagate(t_bdp_req rq);
            t_bdp_rsp    r;
            int unsigned wx, wy, su, lb, n, zw;
            t_mask       mx, my, mz, xl, xh, yl, yh, zl, zh, m1, m2, lo, hi, fld;
            bit          bad;
            r  = '0;
            wx = rq.width_x;
            wy = rq.width_y;
            su = rq.shift_or_upper;
            lb = rq.lower_bit;
            mx = low_ones(wx);
            xl = rq.x_lo & mx;
            xh = rq.x_hi & mx;
            yl = rq.y_lo;
            yh = rq.y_hi;
            zl = rq.z_lo;
            zh = rq.z_hi;
            bad = (wx < 1) || (wx > BDP_MAX_WIDTH);
            if (!bad) begin
                case (rq.opcode)
                    OP_EQ: begin
                        lo = (xl | yl) & mx;
                        hi = xh & yh & mx;
                        r.new_x_lo = lo;
                        r.new_x_hi = hi;
                        if ((lo & ~hi) != '0) begin
                            r.eq_lo = 1'b0;
                            r.eq_hi = 1'b0;
                        end else if (lo == hi) begin
                            r.eq_lo = 1'b1;
                            r.eq_hi = 1'b1;
                        end else begin
                            r.eq_lo = 1'b0;
                            r.eq_hi = 1'b1;
                        end
                    end
                    OP_NOT: begin
                        zl &= mx;
                        zh &= mx;
                        r.new_x_lo = (xl | ~zh) & mx;
                        r.new_x_hi = xh & ~zl & mx;
                        r.new_z_lo = (zl | ~xh) & mx;
                        r.new_z_hi = zh & ~xl & mx;
                    end
                    OP_SHL, OP_SHR: begin
                        // clamp the shift amount to the operand width
                        n = (su > wx) ? wx : su;
                        zl &= mx;
                        zh &= mx;
                        if (rq.opcode == OP_SHR) begin
                            m1 = low_ones(n);
                            m2 = low_ones(wx - n);
                            r.new_x_lo = (xl | (zl << n)) & mx;
                            r.new_x_hi = ((zh << n) | m1) & xh & mx;
                            r.new_z_lo = ((xl >> n) | zl) & m2;
                            r.new_z_hi = (xh >> n) & zh;
                        end else begin
                            m1 = mx & ~low_ones(wx - n);
                            m2 = (low_ones(wx - n) << n) & mx;
                            r.new_x_lo = (xl | (zl >> n)) & mx;
                            r.new_x_hi = ((zh >> n) | m1) & xh & mx;
                            r.new_z_lo = ((xl << n) | zl) & m2;
                            r.new_z_hi = (xh << n) & zh & mx;
                        end
                    end
                    OP_AND: begin
                        yl &= mx;
                        yh &= mx;
                        zl &= mx;
                        zh &= mx;
                        r.new_x_lo = (xl | zl) & mx;
                        r.new_x_hi = xh & ~(~zh & yl) & mx;
                        r.new_y_lo = (yl | zl) & mx;
                        r.new_y_hi = yh & ~(~zh & xl) & mx;
                        r.new_z_lo = (zl | (xl & yl)) & mx;
                        r.new_z_hi = zh & xh & yh & mx;
                    end
                    OP_SLICE: begin
                        if (su < lb || su >= wx) begin
                            bad = 1'b1;
                        end else begin
                            zw  = su - lb + 1;
                            mz  = low_ones(zw);
                            lo  = ((xl >> lb) | zl) & mz;
                            hi  = (xh >> lb) & zh & mz;
                            fld = mz << lb;
                            r.new_z_lo = lo;
                            r.new_z_hi = hi;
                            r.new_x_lo = ((xl & ~fld) | (lo << lb)) & mx;
                            r.new_x_hi = ((xh & ~fld) | (hi << lb)) & mx;
                        end
                    end
                    OP_CONCAT: begin
                        if (wy < 1 || wy > BDP_MAX_WIDTH || wx + wy > BDP_MAX_WIDTH) begin
                            bad = 1'b1;
                        end else begin
                            my = low_ones(wy);
                            r.new_x_lo = ((zl >> wy) | xl) & mx;
                            r.new_x_hi = (zh >> wy) & xh & mx;
                            r.new_y_lo = (zl | yl) & my;
                            r.new_y_hi = zh & yh & my;
                            r.new_z_lo = (r.new_x_lo << wy) | r.new_y_lo;
                            r.new_z_hi = (r.new_x_hi << wy) | r.new_y_hi;
                        end
                    end
                    default: begin
                        bad = 1'b1;
                    end
                endcase
            end
            if (bad) begin
                r = '0;
                r.bad_request = 1'b1;
            end
            return r;
        endfunction

        function void note_request(t_bdp_req rq);
            awaited.push_back(propagate(rq));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                domain_errors++;
                if (domain_errors <= 10) begin
                    $display("mismatch in %s: expected %h, got %h", name, want, got);
                end
            end
        endfunction

        function void check_response(t_bdp_rsp got);
            t_bdp_rsp want;
            words_checked++;
            if (awaited.size() == 0) begin
                domain_errors++;
                if (domain_errors <= 10) begin
                    $display("unexpected result word: bad_request=%b new_z_lo=%h",
                             got.bad_request, got.new_z_lo);
                end
                return;
            end
            want = awaited.pop_front();
            compare_field("new_x_lo", want.new_x_lo, got.new_x_lo);
            compare_field("new_x_hi", want.new_x_hi, got.new_x_hi);
            compare_field("new_y_lo", want.new_y_lo, got.new_y_lo);
            compare_field("new_y_hi", want.new_y_hi, got.new_y_hi);
            compare_field("new_z_lo", want.new_z_lo, got.new_z_lo);
            compare_field("new_z_hi", want.new_z_hi, got.new_z_hi);
            compare_field("eq_lo", 64'(want.eq_lo), 64'(got.eq_lo));
            compare_field("eq_hi", 64'(want.eq_hi), 64'(got.eq_hi));
            compare_field("bad_request", 64'(want.bad_request), 64'(got.bad_request));
        endfunction
    endclass

    localparam t_mask ONES = '1;
    localparam t_mask NONE = '0;
    localparam t_mask ALT  = 64'hA5A5_5A5A_F00F_0FF0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdp_if #(.t_payload(t_bdp_req)) in_ch ();
    bdp_if #(.t_payload(t_bdp_rsp)) out_ch ();

    domain_scoreboard board = new();

    bitvector_domain_propagator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned idle_span();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 60) begin
            return 0;
        end
        if (p < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic t_mask rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void rand_domain(output t_mask lo, output t_mask hi);
        t_mask v, k;
        if ($urandom_range(0, 9) < 7) begin
            v  = rand_word();
            k  = rand_word();
            lo = v & k;
            hi = v | ~k;
        end else begin
            lo = rand_word();
            hi = rand_word();
        end
    endfunction

    function automatic t_bdp_req directed_word(t_opcode op, int unsigned wx, int unsigned wy,
                                               int unsigned su, int unsigned lb,
                                               t_mask xl, t_mask xh, t_mask yl, t_mask yh,
                                               t_mask zl, t_mask zh);
        t_bdp_req rq;
        rq.opcode         = op;
        rq.width_x        = t_width'(wx);
        rq.width_y        = t_width'(wy);
        rq.shift_or_upper = t_width'(su);
        rq.lower_bit      = BDP_LOWER_W'(lb);
        rq.x_lo           = xl;
        rq.x_hi           = xh;
        rq.y_lo           = yl;
        rq.y_hi           = yh;
        rq.z_lo           = zl;
        rq.z_hi           = zh;
        return rq;
    endfunction

    function automatic t_bdp_req random_request();
        t_bdp_req    rq;
        int unsigned wx, lb;
        t_mask       v, k1, k2;
        rq.opcode = ($urandom_range(0, 99) < 96) ? t_opcode'($urandom_range(0, 6)) : OP_RSVD;
        v  = rand_word();
        k1 = rand_word();
        rq.x_lo = v & k1;
        rq.x_hi = v | ~k1;
        if (rq.opcode == OP_EQ && $urandom_range(0, 2) != 0) begin
            // y knows every bit that x leaves open, so the merge is fixed unless v is altered first
            k2 = ~k1 | rand_word();
            if ($urandom_range(0, 3) == 0) begin
                v ^= rand_word();
            end
            rq.y_lo = v & k2;
            rq.y_hi = v | ~k2;
        end else begin
            rand_domain(rq.y_lo, rq.y_hi);
        end
        rand_domain(rq.z_lo, rq.z_hi);
        case ($urandom_range(0, 9))
            0: wx = $urandom_range(0, 1) ? 1 : BDP_MAX_WIDTH;
            1: wx = $urandom_range(0, 127);
            default: wx = $urandom_range(1, BDP_MAX_WIDTH);
        endcase
        rq.width_y        = t_width'($urandom_range(0, 127));
        rq.shift_or_upper = t_width'($urandom_range(0, 127));
        rq.lower_bit      = BDP_LOWER_W'($urandom_range(0, 63));
        if (wx >= 1 && wx <= BDP_MAX_WIDTH && $urandom_range(0, 9) != 0) begin
            case (rq.opcode)
                OP_SHL, OP_SHR: begin
                    rq.shift_or_upper = t_width'($urandom_range(0, wx));
                end
                OP_SLICE: begin
                    lb = $urandom_range(0, wx - 1);
                    rq.lower_bit      = BDP_LOWER_W'(lb);
                    rq.shift_or_upper = t_width'($urandom_range(lb, wx - 1));
                end
                OP_CONCAT: begin
                    if (wx == BDP_MAX_WIDTH) begin
                        wx = $urandom_range(1, BDP_MAX_WIDTH - 1);
                    end
                    rq.width_y = t_width'($urandom_range(1, BDP_MAX_WIDTH - wx));
                end
                default: ;
            endcase
        end
        rq.width_x = t_width'(wx);
        return rq;
    endfunction

    task automatic send_word(input t_bdp_req rq);
        in_ch.valid <= 1'b1;
        in_ch.data  <= rq;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        board.note_request(rq);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles != 0) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= random_request();
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    initial begin : stimulus
        int unsigned i;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        i_rst_n     = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(directed_word(OP_EQ, 64, 0, 0, 0, NONE, ONES, NONE, ONES, NONE, NONE));
        send_word(directed_word(OP_EQ, 64, 0, 0, 0, ALT, ALT, ALT, ONES, ONES, ONES));
        send_word(directed_word(OP_EQ, 1, 0, 0, 0, ONES, ONES, NONE, NONE, NONE, NONE));
        send_word(directed_word(OP_NOT, 64, 0, 0, 0, ONES, ONES, ONES, ONES, ONES, ONES));
        send_word(directed_word(OP_NOT, 1, 0, 0, 0, NONE, NONE, NONE, NONE, NONE, NONE));
        send_word(directed_word(OP_SHL, 64, 0, 0, 0, ALT, ONES, NONE, NONE, NONE, ONES));
        send_word(directed_word(OP_SHL, 64, 0, 64, 0, ALT, ONES, NONE, NONE, ALT, ONES));
        // masks full of ones above the width must be ignored
        send_word(directed_word(OP_SHL, 33, 0, 5, 0, ONES, ONES, ONES, ONES, ONES, ONES));
        send_word(directed_word(OP_SHL, 16, 0, 127, 0, ALT, ONES, NONE, NONE, NONE, ONES));
        send_word(directed_word(OP_SHR, 64, 0, 63, 0, ALT, ONES, NONE, NONE, ~ALT, ONES));
        send_word(directed_word(OP_SHR, 10, 0, 100, 0, ALT, ONES, NONE, NONE, NONE, ONES));
        send_word(directed_word(OP_AND, 64, 0, 0, 0, ALT, ONES, ~ALT, ONES, NONE, ALT));
        send_word(directed_word(OP_AND, 1, 0, 0, 0, ONES, ONES, ONES, ONES, NONE, ONES));
        send_word(directed_word(OP_SLICE, 64, 0, 63, 0, ALT, ONES, NONE, NONE, ~ALT, ONES));
        send_word(directed_word(OP_SLICE, 64, 0, 40, 40, NONE, ONES, NONE, NONE, ONES, ONES));
        send_word(directed_word(OP_SLICE, 32, 0, 10, 20, ALT, ONES, NONE, NONE, NONE, ONES));
        send_word(directed_word(OP_SLICE, 32, 0, 32, 0, ALT, ONES, NONE, NONE, NONE, ONES));
        send_word(directed_word(OP_CONCAT, 32, 32, 0, 0, ALT, ONES, ~ALT, ONES, ONES, ONES));
        send_word(directed_word(OP_CONCAT, 1, 63, 0, 0, NONE, ONES, ALT, ONES, ALT, ALT));
        send_word(directed_word(OP_CONCAT, 63, 1, 0, 0, ALT, ONES, NONE, ONES, NONE, ONES));
        send_word(directed_word(OP_CONCAT, 40, 30, 0, 0, ALT, ONES, ALT, ONES, ALT, ONES));
        send_word(directed_word(OP_CONCAT, 8, 0, 0, 0, ALT, ONES, ALT, ONES, ALT, ONES));
        send_word(directed_word(OP_CONCAT, 8, 127, 127, 63, ALT, ONES, ALT, ONES, ALT, ONES));
        send_word(directed_word(OP_EQ, 0, 0, 0, 0, ALT, ONES, ALT, ONES, ALT, ONES));
        send_word(directed_word(OP_NOT, 65, 0, 0, 0, ALT, ONES, ALT, ONES, ALT, ONES));
        send_word(directed_word(OP_AND, 127, 0, 0, 0, ALT, ONES, ALT, ONES, ALT, ONES));
        send_word(directed_word(OP_RSVD, 64, 1, 1, 1, ALT, ONES, ALT, ONES, ALT, ONES));

        for (i = 0; i < 1825; i++) begin
            // every fifth block of a hundred words goes back to back
            if (((i / 100) % 5) != 4) begin
                pause_sender(idle_span());
            end
            send_word(random_request());
        end
        in_ch.valid <= 1'b0;

        while (board.awaited.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (board.domain_errors == 0 && board.awaited.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned hold_left;
        int unsigned cycle_no;
        bit          squeezed;
        hold_left    = 0;
        cycle_no     = 0;
        squeezed     = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cycle_no++;
            // hold off once for a long stretch so the block backs up into its input
            if (!squeezed && board.words_checked >= 400) begin
                squeezed  = 1'b1;
                hold_left = 160;
            end
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (((cycle_no / 300) % 4) != 3) begin
                    hold_left = idle_span();
                end
            end
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                board.check_response(out_ch.data);
            end
        end
    end

    initial begin : watchdog
        #12_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: bitvector_domain_propagator_top.f
hw/rtl/bdp_pkg.sv
hw/rtl/bdp_if.sv
hw/rtl/bitvector_domain_propagator_top.sv
hw/rtl/bdp_checker.sv
bench/testbench.sv
